FILE: rtl/amd_pkg.sv
//------------------------------------------------------------------------------
// amd_pkg
// shared types, constants and the cordic angle table for the decomposer
//------------------------------------------------------------------------------
package amd_pkg;

	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;

	typedef struct packed {
		logic [31:0] e0;
		logic [31:0] e1;
		logic [31:0] e2;
		logic [31:0] e3;
		logic [1:0]  col;
	} col_req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] tz;
		logic [18:0] rx;
		logic [18:0] ry;
		logic [18:0] rz;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] sz;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQRT,
		ST_DIV,
		ST_ASIN_SQ,
		ST_ASIN_RT,
		ST_ATAN,
		ST_OUT
	} state_t;

	function automatic logic signed [35:0] atan_entry(input logic [4:0] k);
		logic signed [35:0] v;
		case (k)
			5'd0:  v = 36'sd843314857;
			5'd1:  v = 36'sd497837829;
			5'd2:  v = 36'sd263043837;
			5'd3:  v = 36'sd133525159;
			5'd4:  v = 36'sd67021687;
			5'd5:  v = 36'sd33543516;
			5'd6:  v = 36'sd16775851;
			5'd7:  v = 36'sd8388437;
			5'd8:  v = 36'sd4194283;
			5'd9:  v = 36'sd2097149;
			5'd31: v = 36'sd0;
			default: v = 36'sd1 <<< (5'd30 - k);
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/amd_front.sv
//------------------------------------------------------------------------------
// amd_front
// accepts column requests and places them in a short queue
//------------------------------------------------------------------------------
module amd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	input  amd_pkg::col_req_t   s_req,
	output logic                q_valid,
	input  logic                q_ready,
	output amd_pkg::col_req_t   q_req
);

	amd_pkg::col_req_t mem_q [4];
	logic [2:0] wp_q, rp_q;
	logic push, pop;

	assign s_ready = (wp_q - rp_q) != 3'd4;
	assign q_valid = wp_q != rp_q;
	assign push = s_valid && s_ready;
	assign pop = q_valid && q_ready;
	assign q_req = mem_q[rp_q[1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q[1:0]] <= s_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 3'd1;
			if (pop) rp_q <= rp_q + 3'd1;
		end
	end

endmodule

FILE: rtl/amd_back.sv
//------------------------------------------------------------------------------
// amd_back
// stores columns and runs the shared root, divide and cordic steps
//------------------------------------------------------------------------------
module amd_back #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  amd_pkg::col_req_t   q_req,
	input  logic [15:0]         tol,
	output logic                r_valid,
	input  logic                r_ready,
	output amd_pkg::result_t    r_data
);

	localparam int SH = 30 - FRAC_BITS;
	localparam logic signed [35:0] HALF = 36'sd1 <<< (SH - 1);
	localparam logic signed [35:0] PI_F = (amd_pkg::PI_Q30 + HALF) >>> SH;

	amd_pkg::state_t st_q, st_d;
	logic [31:0] m_q [16];
	logic [5:0]  cnt_q;
	logic [1:0]  idx_q;
	logic [3:0]  div_q;
	logic [65:0] rem_q;
	logic [63:0] rad_q;
	logic [31:0] root_q;
	logic [32:0] dr_q;
	logic [31:0] dd_q;
	logic [30:0] qt_q;
	logic [31:0] len_q [3];
	logic signed [31:0] n_q [9];
	logic signed [35:0] cx_q, cy_q, cz_q;
	logic [1:0]  ang_q;
	logic signed [35:0] ang_r_q [3];
	logic        gim_q;
	amd_pkg::result_t res_q;
	logic        rv_q;

	logic signed [31:0] m15;
	logic [31:0] m15_mag;
	logic [31:0] el;
	logic [31:0] el_mag;
	logic [65:0] trial;
	logic [65:0] rem_nx;
	logic [31:0] root_nx;
	logic [33:0] dtrial;
	logic signed [31:0] tcl;
	logic [31:0] t_mag;
	logic signed [35:0] ay, ax, dxs, dys;
	logic [4:0]  k;
	logic signed [35:0] rnd;
	logic signed [35:0] outang [3];

	assign q_ready = (st_q == amd_pkg::ST_IDLE) && !rv_q;
	assign r_valid = rv_q;
	assign r_data = res_q;
	assign m15 = m_q[15];
	assign m15_mag = m15[31] ? 32'd0 - m15 : m15;
	assign el = m_q[{idx_q, div_q[1:0]}];
	assign el_mag = el[31] ? 32'd0 - el : el;
	assign trial = {rem_q[63:0], rad_q[63:62]} - {32'd0, root_q, 2'b01};
	assign rem_nx = trial[65] ? {rem_q[63:0], rad_q[63:62]} : trial;
	assign root_nx = {root_q[30:0], ~trial[65]};
	assign dtrial = {1'b0, dr_q} - {2'b00, dd_q};
	assign tcl = (n_q[2] == 32'sh40000000) ? -32'sh40000000 :
		(n_q[2] == -32'sh40000000) ? 32'sh40000000 : -n_q[2];
	assign t_mag = tcl[31] ? 32'd0 - tcl : tcl;
	assign k = 5'(cnt_q);
	assign dxs = cy_q >>> k;
	assign dys = cx_q >>> k;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd = (ang_r_q[i] + HALF) >>> SH;
			if (rnd > PI_F) outang[i] = PI_F;
			else if (rnd < -PI_F) outang[i] = -PI_F;
			else outang[i] = rnd;
		end
		ay = '0;
		ax = '0;
		case (ang_q)
			2'd0: begin ay = 36'(tcl); ax = {4'd0, root_q}; end
			2'd1: begin
				ay = gim_q ? -36'(n_q[6]) : 36'(n_q[5]);
				ax = gim_q ? 36'(n_q[4]) : 36'(n_q[8]);
			end
			default: begin ay = 36'(n_q[1]); ax = 36'(n_q[0]); end
		endcase
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			amd_pkg::ST_IDLE:
				if (q_valid && !rv_q && q_req.col == 2'd3) st_d = amd_pkg::ST_LOAD;
			amd_pkg::ST_LOAD:
				st_d = (m15_mag <= {16'd0, tol}) ? amd_pkg::ST_OUT : amd_pkg::ST_SQRT;
			amd_pkg::ST_SQRT:
				if (cnt_q == 6'd31) st_d = amd_pkg::ST_DIV;
			amd_pkg::ST_DIV:
				if (cnt_q == 6'd31) begin
					if (div_q[1:0] == 2'd2) st_d = (idx_q == 2'd2) ?
						amd_pkg::ST_ASIN_SQ : amd_pkg::ST_SQRT;
				end
			amd_pkg::ST_ASIN_SQ: st_d = amd_pkg::ST_ASIN_RT;
			amd_pkg::ST_ASIN_RT:
				if (cnt_q == 6'd31) st_d = amd_pkg::ST_ATAN;
			amd_pkg::ST_ATAN:
				if (cnt_q == 6'(CORDIC_ITERATIONS) &&
					(ang_q == 2'd2 || (ang_q == 2'd1 && gim_q))) st_d = amd_pkg::ST_OUT;
			amd_pkg::ST_OUT: st_d = amd_pkg::ST_IDLE;
			default: st_d = amd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == amd_pkg::ST_IDLE && q_valid && !rv_q) begin
			m_q[{q_req.col, 2'd0}] <= q_req.e0;
			m_q[{q_req.col, 2'd1}] <= q_req.e1;
			m_q[{q_req.col, 2'd2}] <= q_req.e2;
			m_q[{q_req.col, 2'd3}] <= q_req.e3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= amd_pkg::ST_IDLE;
			rv_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			div_q <= '0;
			ang_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == amd_pkg::ST_OUT) rv_q <= 1'b1;
			else if (r_ready) rv_q <= 1'b0;
			case (st_q)
				amd_pkg::ST_LOAD: begin
					idx_q <= '0;
					div_q <= '0;
					cnt_q <= '0;
				end
				amd_pkg::ST_SQRT: begin
					if (cnt_q == 6'd0 && div_q == 4'd0) begin
						rad_q <= 64'(el_mag) * 64'(el_mag);
						div_q <= 4'd1;
					end else if (div_q == 4'd1 || div_q == 4'd2) begin
						rad_q <= rad_q + 64'(el_mag) * 64'(el_mag);
						div_q <= div_q + 4'd1;
						rem_q <= '0;
						root_q <= '0;
					end else begin
						rem_q <= rem_nx;
						root_q <= root_nx;
						rad_q <= {rad_q[61:0], 2'b00};
						if (cnt_q == 6'd31) begin
							cnt_q <= '0;
							div_q <= 4'd0;
							len_q[idx_q] <= root_nx;
							dd_q <= root_nx;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				amd_pkg::ST_DIV: begin
					if (cnt_q == 6'd0 && div_q[3] == 1'b0) begin
						dr_q <= {1'b0, el_mag};
						qt_q <= '0;
						div_q[3] <= 1'b1;
					end else begin
						if (!dtrial[33] && dd_q != 32'd0) begin
							dr_q <= {dtrial[31:0], 1'b0};
							qt_q <= {qt_q[29:0], 1'b1};
						end else begin
							dr_q <= {dr_q[31:0], 1'b0};
							qt_q <= {qt_q[29:0], 1'b0};
						end
						if (cnt_q == 6'd31) begin
							cnt_q <= '0;
							n_q[4'(idx_q) * 4'd3 + 4'(div_q[1:0])] <= el[31] ?
								-$signed({1'b0, qt_q}) : $signed({1'b0, qt_q});
							if (div_q[1:0] == 2'd2) begin
								div_q <= '0;
								idx_q <= idx_q + 2'd1;
							end else begin
								div_q <= {2'b00, div_q[1:0] + 2'd1};
							end
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				amd_pkg::ST_ASIN_SQ: begin
					rad_q <= 64'(61'h1000000000000000 - 61'(t_mag) * 61'(t_mag));
					rem_q <= '0;
					root_q <= '0;
					cnt_q <= '0;
					gim_q <= !(n_q[2] < 32'sh40000000 && n_q[2] > -32'sh40000000);
				end
				amd_pkg::ST_ASIN_RT: begin
					rem_q <= rem_nx;
					root_q <= root_nx;
					rad_q <= {rad_q[61:0], 2'b00};
					if (cnt_q == 6'd31) begin
						cnt_q <= 6'd63;
						ang_q <= 2'd0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				amd_pkg::ST_ATAN: begin
					if (cnt_q == 6'd63) begin
						if (ax == 0 && ay == 0) begin
							cx_q <= '0; cy_q <= '0; cz_q <= '0;
						end else if (ax < 0) begin
							cx_q <= -ax; cy_q <= -ay;
							cz_q <= (ay >= 0) ? amd_pkg::PI_Q30 : -amd_pkg::PI_Q30;
						end else begin
							cx_q <= ax; cy_q <= ay; cz_q <= '0;
						end
						cnt_q <= '0;
					end else if (cnt_q == 6'(CORDIC_ITERATIONS)) begin
						ang_r_q[ang_q] <= (cx_q == 0 && cy_q == 0) ? 36'sd0 : cz_q;
						ang_q <= ang_q + 2'd1;
						cnt_q <= 6'd63;
					end else begin
						if (cy_q > 0) begin
							cx_q <= cx_q + dxs; cy_q <= cy_q - dys;
							cz_q <= cz_q + amd_pkg::atan_entry(k);
						end else begin
							cx_q <= cx_q - dxs; cy_q <= cy_q + dys;
							cz_q <= cz_q - amd_pkg::atan_entry(k);
						end
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == amd_pkg::ST_OUT) begin
			if (m15_mag <= {16'd0, tol}) begin
				res_q <= '0;
			end else begin
				res_q.ok <= 1'b1;
				res_q.tx <= m_q[12];
				res_q.ty <= m_q[13];
				res_q.tz <= m_q[14];
				res_q.ry <= 19'(outang[0]);
				res_q.rx <= 19'(outang[1]);
				res_q.rz <= gim_q ? 19'd0 : 19'(outang[2]);
				res_q.sx <= len_q[0];
				res_q.sy <= len_q[1];
				res_q.sz <= len_q[2];
			end
		end
	end

endmodule

FILE: rtl/affine_matrix_decompose.sv
//------------------------------------------------------------------------------
// affine_matrix_decompose
// splits a column-major affine matrix into translation, scale and euler xyz
//------------------------------------------------------------------------------
// columns arrive one per request on s_axis, the column index on s_axis_tuser;
// column 3 starts the computation from the latest stored columns 0..2 and
// yields one result on m_axis, with ok on m_axis_tuser
// a four-deep request queue parts the input side from the compute engine
// columns 0..2 are stored by the engine as they are taken
// column 3 runs three column lengths, nine divides and an asin root on the
// shared bit-serial root/divide unit, then the angles on the single cordic
// unit, one angle fewer in the gimbal case
// a failing matrix (small m33) goes from LOAD straight to OUT
// the next matrix starts only once the result has been taken
// cfg writes zero_tolerance; write only while idle
// reset clears control state and sets zero_tolerance to 0
// a stalled m_axis holds its result and the engine waits, the queue fills,
// then s_axis_tready drops
//------------------------------------------------------------------------------
module affine_matrix_decompose #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// element_0..element_3
	input  logic [127:0] s_axis_tdata,
	// column_index
	input  logic [1:0]   s_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// translation_x/y/z, rotation_x/y/z, scale_x/y/z, zero pad
	output logic [255:0] m_axis_tdata,
	// ok
	output logic         m_axis_tuser
);

	amd_pkg::col_req_t s_req, q_req;
	amd_pkg::result_t res;
	logic q_valid, q_ready;
	logic [15:0] tol_q;

	assign s_req.col = s_axis_tuser;
	assign s_req.e0 = s_axis_tdata[31:0];
	assign s_req.e1 = s_axis_tdata[63:32];
	assign s_req.e2 = s_axis_tdata[95:64];
	assign s_req.e3 = s_axis_tdata[127:96];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= '0;
		else if (cfg_valid) tol_q <= cfg_data;
	end

	amd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_req(s_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	amd_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .tol(tol_q),
		.r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data(res)
	);

	assign m_axis_tdata = {7'd0, res.sz, res.sy, res.sx, res.rz, res.ry, res.rx,
		res.tz, res.ty, res.tx};
	assign m_axis_tuser = res.ok;

endmodule

FILE: rtl/amd_checker.sv
//------------------------------------------------------------------------------
// amd_checker
// port-level checks on the decomposer
//------------------------------------------------------------------------------
module amd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [255:0] m_axis_tdata,
	input logic         m_axis_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result dropped while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("failed result not zero");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[255:249] == '0)
		else $error("pad bits set");

endmodule

bind affine_matrix_decompose amd_checker u_amd_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Testbench for affine_matrix_decompose. Matrices go in one column per
// request. Every column 3 request is scored against a bit-exact fixed-point
// model of the translation, column length and Euler XYZ decomposition. The
// run covers directed corner matrices, random matrices under several idle
// and stall mixes, zero_tolerance settings, and a long output hold-off.
//------------------------------------------------------------------------------
module tb_top;

	localparam int FRAC_BITS = 16;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int SETTLE = 700;
	localparam logic [1:0] COL_LAST = 2'd3;
	localparam logic [31:0] MAX_NEG = 32'h8000_0000;
	localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam longint ONE_Q30 = 64'sd1 << 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [255:0] m_axis_tdata;
	logic m_axis_tuser;

	logic [31:0] matrix_mem [16];
	logic [15:0] tol_reg;
	amd_pkg::result_t result_q [$];
	longint cordic_angle [32];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 0;
	int hold_left = 0;

	affine_matrix_decompose #(
		.FRAC_BITS(FRAC_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100ms;
		$display("FAIL");
		$finish;
	end

	function automatic logic [63:0] root64(input logic [63:0] n);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint vector_angle(input longint y, input longint x);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(amd_pkg::PI_Q30) : -longint'(amd_pkg::PI_Q30);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
			dx = y >>> (i % 32);
			dy = x >>> (i % 32);
			if (y > 0) begin
				x += dx; y -= dy; z += cordic_angle[i % 32];
			end else begin
				x -= dx; y += dy; z -= cordic_angle[i % 32];
			end
		end
		return z;
	endfunction

	function automatic logic [18:0] round_angle(input longint z);
		int sh;
		longint half, pi_f, r;
		sh = 30 - FRAC_BITS;
		half = 64'sd1 << (sh - 1);
		pi_f = (longint'(amd_pkg::PI_Q30) + half) >>> sh;
		r = (z + half) >>> sh;
		if (r > pi_f) r = pi_f;
		if (r < -pi_f) r = -pi_f;
		return r[18:0];
	endfunction

	function automatic longint unit_elem(input longint e, input logic [63:0] len);
		logic [63:0] q;
		if (len == 0)
			return 0;
		q = (abs64(e) << 30) / len;
		return e < 0 ? -longint'(q) : longint'(q);
	endfunction

	// updates the stored matrix and, on column 3, queues the expected result
	task automatic predict_decompose(input logic [1:0] col, input logic [31:0] e [4]);
		amd_pkg::result_t res;
		longint m [16];
		longint unit [3][3];
		logic [63:0] len [3];
		logic [63:0] acc, cosv;
		longint t, ax, ay, az;
		for (int r = 0; r < 4; r++)
			matrix_mem[col * 4 + r] = e[r];
		if (col != COL_LAST)
			return;
		res = '0;
		for (int r = 0; r < 16; r++)
			m[r] = longint'(signed'(matrix_mem[r]));
		if (abs64(m[15]) > {48'd0, tol_reg}) begin
			res.ok = 1'b1;
			res.tx = m[12][31:0];
			res.ty = m[13][31:0];
			res.tz = m[14][31:0];
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int r = 0; r < 3; r++)
					acc += abs64(m[c * 4 + r]) * abs64(m[c * 4 + r]);
				len[c] = root64(acc);
				for (int r = 0; r < 3; r++)
					unit[c][r] = unit_elem(m[c * 4 + r], len[c]);
			end
			res.sx = len[0][31:0];
			res.sy = len[1][31:0];
			res.sz = len[2][31:0];
			t = -unit[0][2];
			if (t > ONE_Q30) t = ONE_Q30;
			if (t < -ONE_Q30) t = -ONE_Q30;
			cosv = root64((64'd1 << 60) - abs64(t) * abs64(t));
			ay = vector_angle(t, longint'(cosv));
			if (abs64(unit[0][2]) < (64'd1 << 30)) begin
				ax = vector_angle(unit[1][2], unit[2][2]);
				az = vector_angle(unit[0][1], unit[0][0]);
				res.rz = round_angle(az);
			end else begin
				ax = vector_angle(-unit[2][0], unit[1][1]);
				res.rz = '0;
			end
			res.rx = round_angle(ax);
			res.ry = round_angle(ay);
		end
		result_q.push_back(res);
	endtask

	task automatic cmp(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %h actual %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		amd_pkg::result_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			if (result_q.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				exp_r = result_q.pop_front();
				cmp("ok", 32'(exp_r.ok), 32'(m_axis_tuser));
				cmp("translation_x", exp_r.tx, m_axis_tdata[31:0]);
				cmp("translation_y", exp_r.ty, m_axis_tdata[63:32]);
				cmp("translation_z", exp_r.tz, m_axis_tdata[95:64]);
				cmp("rotation_x", 32'(exp_r.rx), 32'(m_axis_tdata[114:96]));
				cmp("rotation_y", 32'(exp_r.ry), 32'(m_axis_tdata[133:115]));
				cmp("rotation_z", 32'(exp_r.rz), 32'(m_axis_tdata[152:134]));
				cmp("scale_x", exp_r.sx, m_axis_tdata[184:153]);
				cmp("scale_y", exp_r.sy, m_axis_tdata[216:185]);
				cmp("scale_z", exp_r.sz, m_axis_tdata[248:217]);
			end
		end
	end

	// output side: random stall, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_col(input logic [1:0] col, input logic [31:0] e0, input logic [31:0] e1,
			input logic [31:0] e2, input logic [31:0] e3);
		logic [31:0] e [4];
		e = '{e0, e1, e2, e3};
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {e3, e2, e1, e0};
		s_axis_tuser <= col;
		do @(posedge clk); while (!s_axis_tready);
		predict_decompose(col, e);
	endtask

	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		tol_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(9))
			0: return MAX_NEG;
			1: return MAX_POS;
			2: return 32'd0;
			3, 4, 5: return $urandom;
			default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
		endcase
	endfunction

	task automatic send_rand_col(input logic [1:0] col);
		logic [31:0] e [4];
		for (int r = 0; r < 4; r++)
			e[r] = rand_elem();
		if (col == 2'd0 && $urandom_range(9) == 0) begin
			e[0] = 0;
			e[1] = 0;
			e[2] = $urandom_range(1) ? ONE : -ONE;
		end
		if (col != COL_LAST && $urandom_range(19) == 0) begin
			e[0] = 0; e[1] = 0; e[2] = 0;
		end
		if (col == COL_LAST && $urandom_range(7) == 0)
			e[3] = $urandom_range(1) ? tol_reg + $urandom_range(1) : -(tol_reg + $urandom_range(1));
		send_col(col, e[0], e[1], e[2], e[3]);
	endtask

	task automatic send_rand_matrix;
		int order [3];
		order = '{0, 1, 2};
		order.shuffle();
		if ($urandom_range(9) == 0)
			send_rand_col(2'($urandom_range(3)));
		foreach (order[i])
			send_rand_col(2'(order[i]));
		if ($urandom_range(9) == 0)
			send_rand_col(2'($urandom_range(2)));
		send_rand_col(COL_LAST);
	endtask

	task automatic test_corner_matrices;
		send_col(0, ONE, 0, 0, 0);
		send_col(1, 0, ONE, 0, 0);
		send_col(2, 0, 0, ONE, 0);
		send_col(3, 32'h0003_0000, -32'h0002_0000, 32'h0000_8000, ONE);
		send_col(3, MAX_POS, MAX_NEG, 0, 0);
		send_col(0, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
		send_col(1, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
		send_col(2, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
		send_col(3, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
		send_col(0, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
		send_col(1, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
		send_col(2, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
		send_col(3, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
		// gimbal lock both ways
		send_col(0, 0, 0, ONE, 0);
		send_col(1, 0, ONE, 0, 0);
		send_col(2, -ONE, 0, 0, 0);
		send_col(3, 0, 0, 0, ONE);
		send_col(0, 0, 0, -32'h0002_0000, 0);
		send_col(3, 1, -1, 0, -1);
		// zero-length column and negative diagonal
		send_col(0, -ONE, 0, 0, 0);
		send_col(1, 0, 0, 0, 0);
		send_col(2, 0, 32'h0000_1000, -ONE, 0);
		send_col(3, 0, 0, 0, -ONE);
	endtask

	task automatic test_random_mix(input int n_mat, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (n_mat) send_rand_matrix();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_output_hold;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1;
		repeat (30) send_rand_matrix();
	endtask

	initial begin
		cordic_angle = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536,
			32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
		foreach (matrix_mem[i])
			matrix_mem[i] = '0;
		tol_reg = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_matrices();
		write_tolerance(16'hffff);
		test_random_mix(100, 0, 0);
		write_tolerance(16'd1);
		test_random_mix(100, 86, 0);
		write_tolerance(16'($urandom));
		test_random_mix(100, 0, 86);
		write_tolerance(16'd0);
		test_random_mix(100, 22, 22);
		test_output_hold();

		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: affine_matrix_decompose.f
rtl/amd_pkg.sv
rtl/amd_front.sv
rtl/amd_back.sv
rtl/affine_matrix_decompose.sv
rtl/amd_checker.sv
test/tb_top.sv
